>>> hdl/msl_pkg.sv
// msl_pkg: shared types and constants for the multi-servo slew limiter.
// Used by msl_front, msl_back and the top level; no dependencies.

package msl_pkg;

    localparam int JOINTS  = 5;
    localparam int ANG_W   = 15;   // hundredths of a degree, 0..18000
    localparam int MRAD_W  = 16;   // signed milliradians
    localparam int CNT_W   = 3;
    localparam int CFG_W   = 30;
    localparam int PULSE_W = 10;
    localparam int IDX_W   = 3;

    // Operation codes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_J0_LIMITS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_J1_LIMITS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_J2_LIMITS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_J3_LIMITS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_J4_LIMITS    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL_STEP  = 3'd5;
    localparam logic [IDX_W-1:0] REG_STARTUP_STEP = 3'd6;
    localparam logic [IDX_W-1:0] REG_REACH_EPS    = 3'd7;

    // Register reset values
    localparam logic [JOINTS-1:0][CFG_W-1:0] LIMITS_RST = {
        30'd393216000, 30'd393216000, 30'd262144000, 30'd393216000, 30'd393216000
    };
    localparam logic [ANG_W-1:0] NORMAL_STEP_RST  = 15'd50;
    localparam logic [ANG_W-1:0] STARTUP_STEP_RST = 15'd15;
    localparam logic [ANG_W-1:0] REACH_EPS_RST    = 15'd20;

    // Startup pose, lane 0 in the low slot
    localparam logic [JOINTS-1:0][ANG_W-1:0] POSE_INIT = {
        15'd9000, 15'd9000, 15'd8000, 15'd0, 15'd0
    };

    localparam logic [CNT_W-1:0] MIN_COMMAND_JOINTS = 3'd4;
    localparam logic [CNT_W-1:0] MAX_COUNT          = 3'd5;

    localparam logic [ANG_W-1:0]         DEG_FULL    = 15'd18000;
    localparam logic signed [MRAD_W-1:0] MRAD_LIM    = 16'sd1570;
    localparam int                       ZERO_LANE   = 0;
    localparam logic [ANG_W-1:0]         ZERO_OFFSET = 15'd9000;
    localparam int                       MIRROR_LANE = 1;

    // floor(x*900/157) for x in 0..3140 as (x*RECIP_DEG) >> DEG_SHIFT
    localparam int              RECIP_DEG_W = 22;
    localparam logic [21:0]     RECIP_DEG   = 22'd3005473;
    localparam int              DEG_SHIFT   = 19;

    // floor(a/40) for a in 0..18000 as (a*RECIP_PULSE) >> PULSE_SHIFT
    localparam logic [ANG_W-1:0]   RECIP_PULSE = 15'd26215;
    localparam int                 PULSE_SHIFT = 20;
    localparam logic [PULSE_W-1:0] PULSE_BASE  = 10'd150;

    typedef struct packed {
        logic [JOINTS-1:0][CFG_W-1:0] limits;
        logic [ANG_W-1:0]             normal_step;
        logic [ANG_W-1:0]             startup_step;
        logic [ANG_W-1:0]             reach_eps;
    } t_cfg;

    typedef struct packed {
        logic                         op;
        logic [JOINTS-1:0][ANG_W-1:0] tgt;
    } t_qentry;

    typedef struct packed {
        logic [JOINTS-1:0][PULSE_W-1:0] pulse;
        logic                           all_reached;
        logic                           slow_mode;
    } t_result;

endpackage

>>> hdl/multi_servo_slew_limiter.sv
// multi_servo_slew_limiter: top level, configuration registers and the
// front / queue / back pipeline. Depends on msl_pkg, msl_front, msl_queue, msl_back.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------------
//  input     in         i_in_valid / o_in_stall    i_operation, i_cmd_count, i_cmd_angle_0..4
//  result    out        o_out_valid / i_out_stall  o_pulse_0..4, o_all_reached, o_slow_mode
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output does not stall. An item is mapped in
// the front in the cycle it is taken and written into the queue; the back pops it and
// loads the result register, so a tick result passes the queue and that register.
// Commands leave no result; short commands are dropped before the queue.
// Output stalls back up through the queue (QUEUE_DEPTH items) into o_in_stall.
// Synchronous active-low reset: startup pose, slow mode on, registers to defaults.

module multi_servo_slew_limiter #(
    parameter int QUEUE_DEPTH = 2    // power of two, 2..16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [msl_pkg::CNT_W-1:0]    i_cmd_count,
    input  logic signed [msl_pkg::MRAD_W-1:0] i_cmd_angle_0,
    input  logic signed [msl_pkg::MRAD_W-1:0] i_cmd_angle_1,
    input  logic signed [msl_pkg::MRAD_W-1:0] i_cmd_angle_2,
    input  logic signed [msl_pkg::MRAD_W-1:0] i_cmd_angle_3,
    input  logic signed [msl_pkg::MRAD_W-1:0] i_cmd_angle_4,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [msl_pkg::PULSE_W-1:0]  o_pulse_0,
    output logic [msl_pkg::PULSE_W-1:0]  o_pulse_1,
    output logic [msl_pkg::PULSE_W-1:0]  o_pulse_2,
    output logic [msl_pkg::PULSE_W-1:0]  o_pulse_3,
    output logic [msl_pkg::PULSE_W-1:0]  o_pulse_4,
    output logic                         o_all_reached,
    output logic                         o_slow_mode,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [msl_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [msl_pkg::CFG_W-1:0]    i_cfg_data
);
    import msl_pkg::*;

    localparam int QW = $bits(t_qentry);

    // configuration registers, raw as written
    logic [JOINTS-1:0][CFG_W-1:0] r_limits;
    logic [ANG_W-1:0]             r_normal_step;
    logic [ANG_W-1:0]             r_startup_step;
    logic [ANG_W-1:0]             r_reach_eps;

    t_cfg    cfg;
    t_qentry fq_data;
    t_qentry qb_data;
    logic    fq_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result result;
    logic [QW-1:0] q_out_bits;
    logic [JOINTS-1:0][MRAD_W-1:0] cmd_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits       <= LIMITS_RST;
            r_normal_step  <= NORMAL_STEP_RST;
            r_startup_step <= STARTUP_STEP_RST;
            r_reach_eps    <= REACH_EPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_J0_LIMITS:    r_limits[0]    <= i_cfg_data;
                REG_J1_LIMITS:    r_limits[1]    <= i_cfg_data;
                REG_J2_LIMITS:    r_limits[2]    <= i_cfg_data;
                REG_J3_LIMITS:    r_limits[3]    <= i_cfg_data;
                REG_J4_LIMITS:    r_limits[4]    <= i_cfg_data;
                REG_NORMAL_STEP:  r_normal_step  <= i_cfg_data[ANG_W-1:0];
                REG_STARTUP_STEP: r_startup_step <= i_cfg_data[ANG_W-1:0];
                REG_REACH_EPS:    r_reach_eps    <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.limits       = r_limits;
    assign cfg.normal_step  = r_normal_step;
    assign cfg.startup_step = r_startup_step;
    assign cfg.reach_eps    = r_reach_eps;

    assign cmd_angle = {i_cmd_angle_4, i_cmd_angle_3, i_cmd_angle_2,
                        i_cmd_angle_1, i_cmd_angle_0};

    // front: take, classify, map angles
    msl_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_cmd_count (i_cmd_count),
        .i_cmd_angle (cmd_angle),
        .i_cfg       (cfg),
        .i_q_full    (q_full),
        .o_q_push    (fq_push),
        .o_q_data    (fq_data)
    );

    // decoupling queue
    msl_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out_bits),
        .i_pop   (q_pop)
    );

    assign qb_data = q_out_bits;

    // back: targets, slew step, pulses
    msl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (qb_data),
        .o_q_pop     (q_pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_pulse_0     = result.pulse[0];
    assign o_pulse_1     = result.pulse[1];
    assign o_pulse_2     = result.pulse[2];
    assign o_pulse_3     = result.pulse[3];
    assign o_pulse_4     = result.pulse[4];
    assign o_all_reached = result.all_reached;
    assign o_slow_mode   = result.slow_mode;

endmodule

>>> hdl/msl_front.sv
// msl_front: accepts items, drops short commands and maps command angles to
// clamped per-joint targets. Depends on msl_pkg.

module msl_front (
    input  logic                                            i_in_valid,
    output logic                                            o_in_stall,
    input  logic                                            i_operation,
    input  logic [msl_pkg::CNT_W-1:0]                       i_cmd_count,
    input  logic [msl_pkg::JOINTS-1:0][msl_pkg::MRAD_W-1:0] i_cmd_angle,
    input  msl_pkg::t_cfg                                   i_cfg,
    input  logic                                            i_q_full,
    output logic                                            o_q_push,
    output msl_pkg::t_qentry                                o_q_data
);
    import msl_pkg::*;

    logic [CNT_W-1:0] cnt_sat;
    logic             cmd_ok;
    logic [ANG_W-1:0] tgt_lane [JOINTS];

    assign cnt_sat    = (i_cmd_count > MAX_COUNT) ? MAX_COUNT : i_cmd_count;
    assign cmd_ok     = (cnt_sat >= MIN_COMMAND_JOINTS);
    assign o_in_stall = i_q_full;
    // short commands are taken and dropped here
    assign o_q_push   = i_in_valid && !i_q_full && ((i_operation == OP_TICK) || cmd_ok);

    for (genvar j = 0; j < JOINTS; j++) begin : g_lane
        logic signed [MRAD_W-1:0]  mrad;
        logic signed [MRAD_W-1:0]  mrad_cl;
        logic [11:0]               xofs;
        logic [33:0]               prod;
        logic [ANG_W-1:0]          deg;
        logic [ANG_W-1:0]          deg_z;
        logic [ANG_W-1:0]          mn;
        logic [ANG_W-1:0]          mx;
        logic [ANG_W-1:0]          lo;
        logic [ANG_W-1:0]          hi;
        logic signed [ANG_W+1:0]   mir;
        logic [ANG_W-1:0]          deg_m;

        always_comb begin
            mrad = (CNT_W'(j) < cnt_sat) ? $signed(i_cmd_angle[j]) : '0;
            if (mrad < -MRAD_LIM) begin
                mrad_cl = -MRAD_LIM;
            end else if (mrad > MRAD_LIM) begin
                mrad_cl = MRAD_LIM;
            end else begin
                mrad_cl = mrad;
            end
            xofs = 12'(mrad_cl + MRAD_LIM);
            prod = {22'd0, xofs} * {12'd0, RECIP_DEG};
            deg  = prod[DEG_SHIFT+ANG_W-1:DEG_SHIFT];

            if (j == ZERO_LANE) begin
                deg_z = (deg >= ZERO_OFFSET) ? ANG_W'(deg - ZERO_OFFSET) : '0;
            end else begin
                deg_z = (deg > DEG_FULL) ? DEG_FULL : deg;
            end

            // soft limits: clamp each to full range, swap when inverted
            mn = (i_cfg.limits[j][ANG_W-1:0] > DEG_FULL) ? DEG_FULL
                                                         : i_cfg.limits[j][ANG_W-1:0];
            mx = (i_cfg.limits[j][2*ANG_W-1:ANG_W] > DEG_FULL) ? DEG_FULL
                                                               : i_cfg.limits[j][2*ANG_W-1:ANG_W];
            lo = (mn > mx) ? mx : mn;
            hi = (mn > mx) ? mn : mx;

            mir = $signed({2'b00, lo}) + $signed({2'b00, hi}) - $signed({2'b00, deg_z});
            if (j == MIRROR_LANE) begin
                if (mir < 0) begin
                    deg_m = '0;
                end else if (mir > $signed({2'b00, DEG_FULL})) begin
                    deg_m = DEG_FULL;
                end else begin
                    deg_m = mir[ANG_W-1:0];
                end
            end else begin
                deg_m = deg_z;
            end

            if (deg_m < lo) begin
                tgt_lane[j] = lo;
            end else if (deg_m > hi) begin
                tgt_lane[j] = hi;
            end else begin
                tgt_lane[j] = deg_m;
            end
        end
    end

    always_comb begin
        o_q_data.op = i_operation;
        for (int k = 0; k < JOINTS; k++) begin
            o_q_data.tgt[k] = tgt_lane[k];
        end
    end

endmodule

>>> hdl/msl_queue.sv
// msl_queue: small register FIFO between front and back.
// Generic width and depth; no package dependency.

module msl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            if (i_pop)  r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

>>> hdl/msl_back.sv
// msl_back: applies queued commands to the targets and steps the joints on
// ticks, with a result register toward the output. Depends on msl_pkg.

module msl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  msl_pkg::t_qentry i_q_data,
    output logic             o_q_pop,
    input  msl_pkg::t_cfg    i_cfg,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output msl_pkg::t_result o_result
);
    import msl_pkg::*;

    logic [JOINTS-1:0][ANG_W-1:0] r_cur;
    logic [JOINTS-1:0][ANG_W-1:0] r_tgt;
    logic                         r_slow;
    logic                         r_seen;
    logic                         r_out_valid;
    t_result                      r_result;

    logic             out_free;
    logic             do_tick;
    logic             do_cmd;
    logic [ANG_W-1:0] step;
    logic             all_reached;
    logic             n_slow;
    t_result          n_result;
    logic [ANG_W-1:0]   n_cur     [JOINTS];
    logic [PULSE_W-1:0] pulse_ln  [JOINTS];
    logic               reach_ln  [JOINTS];

    assign out_free = !r_out_valid || !i_out_stall;
    // commands never wait on the output side
    assign o_q_pop  = i_q_valid && ((i_q_data.op == OP_COMMAND) || out_free);
    assign do_tick  = o_q_pop && (i_q_data.op == OP_TICK);
    assign do_cmd   = o_q_pop && (i_q_data.op == OP_COMMAND);
    assign step     = r_slow ? i_cfg.startup_step : i_cfg.normal_step;

    for (genvar j = 0; j < JOINTS; j++) begin : g_lane
        logic [ANG_W-1:0]   diff;
        logic [ANG_W-1:0]   gap;
        logic               up;
        logic [2*ANG_W-1:0] prod;

        always_comb begin
            up   = (r_cur[j] < r_tgt[j]);
            diff = up ? ANG_W'(r_tgt[j] - r_cur[j]) : ANG_W'(r_cur[j] - r_tgt[j]);
            if (step >= diff) begin
                n_cur[j] = r_tgt[j];
                gap      = '0;
            end else begin
                n_cur[j] = up ? ANG_W'(r_cur[j] + step) : ANG_W'(r_cur[j] - step);
                gap      = ANG_W'(diff - step);
            end
            prod        = {{ANG_W{1'b0}}, n_cur[j]} * {{ANG_W{1'b0}}, RECIP_PULSE};
            pulse_ln[j] = PULSE_BASE + prod[PULSE_SHIFT+PULSE_W-1:PULSE_SHIFT];
            reach_ln[j] = (gap <= i_cfg.reach_eps);
        end
    end

    always_comb begin
        all_reached = 1'b1;
        for (int k = 0; k < JOINTS; k++) begin
            all_reached = all_reached && reach_ln[k];
            n_result.pulse[k] = pulse_ln[k];
        end
        n_slow               = r_slow && !(r_seen && all_reached);
        n_result.all_reached = all_reached;
        n_result.slow_mode   = n_slow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= POSE_INIT;
            r_tgt       <= POSE_INIT;
            r_slow      <= 1'b1;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_cmd) begin
                r_tgt  <= i_q_data.tgt;
                r_seen <= 1'b1;
            end
            if (do_tick) begin
                for (int k = 0; k < JOINTS; k++) begin
                    r_cur[k] <= n_cur[k];
                end
                r_slow <= n_slow;
            end
            if (do_tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tick) r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    for (genvar j = 0; j < JOINTS; j++) begin : g_chk
        a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_tgt[j] <= DEG_FULL) && (r_cur[j] <= DEG_FULL))
            else $error("joint angle out of range");
    end

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> o_out_valid)
        else $error("tick gave no result");

    a_slow_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$rose(r_slow))
        else $error("slow mode came back");

endmodule
